// ===== sv/bwft_pkg.sv =====
// Shared types and codes for the bitmap with lowest-set-bit tracking.
package bwft_pkg;

    localparam int WordBits = 64;
    localparam int IndexBits = 10;
    localparam int PosBits = 6;

    localparam logic [2:0] MODE_SET_BIT   = 3'd0;
    localparam logic [2:0] MODE_CLEAR_BIT = 3'd1;
    localparam logic [2:0] MODE_SET_ALL   = 3'd2;
    localparam logic [2:0] MODE_CLEAR_ALL = 3'd3;
    localparam logic [2:0] MODE_TEST_BIT  = 3'd4;
    localparam logic [2:0] MODE_FIND      = 3'd5;

    localparam logic [1:0] CS_KNOWN   = 2'd0;
    localparam logic [1:0] CS_NONE    = 2'd1;
    localparam logic [1:0] CS_UNKNOWN = 2'd2;

    typedef logic [WordBits-1:0] word_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic bulk_en;
        logic bulk_value;
    } mem_ctl_t;

endpackage

// ===== sv/bwft_mem.sv =====
// Word memory with per-entry valid bits and a bulk fill value.
module bwft_mem
    import bwft_pkg::*;
#(
    parameter int WORD_COUNT = 16,
    parameter int AW = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  mem_ctl_t      ctl,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    input  word_t         wr_data,
    output word_t         rd_word
);

    word_t                 mem [WORD_COUNT];
    word_t                 mem_q_reg;
    logic [WORD_COUNT-1:0] valid_reg;
    logic                  fill_reg;
    logic                  vld_q_reg;
    logic                  fill_q_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            mem_q_reg  <= mem[rd_addr];
            vld_q_reg  <= valid_reg[rd_addr];
            fill_q_reg <= fill_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fill_reg  <= 1'b0;
        end else if (ctl.bulk_en) begin
            valid_reg <= '0;
            fill_reg  <= ctl.bulk_value;
        end else if (ctl.wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // An entry not written since the last bulk operation reads as the fill value.
    assign rd_word = vld_q_reg ? mem_q_reg : {WordBits{fill_q_reg}};

endmodule

// ===== sv/bwft_enc.sv =====
// Two-stage encoder for the lowest set bit of a 64-bit word.
module bwft_enc
    import bwft_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  word_t              word,
    output logic               done,
    output logic [PosBits-1:0] pos
);

    logic [7:0]       nz_next;
    logic [7:0]       nz_reg;
    logic [2:0]       bpos_next [8];
    logic [2:0]       bpos_reg [8];
    logic [PosBits-1:0] pos_next;
    logic [PosBits-1:0] pos_reg;
    logic             v1_reg;
    logic             v2_reg;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            nz_next[b]   = |word[8*b +: 8];
            bpos_next[b] = 3'd0;
            for (int k = 7; k >= 0; k--) begin
                if (word[8*b + k]) begin
                    bpos_next[b] = 3'(k);
                end
            end
        end
    end

    always_comb begin
        pos_next = '0;
        for (int b = 7; b >= 0; b--) begin
            if (nz_reg[b]) begin
                pos_next = {3'(b), bpos_reg[b]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        nz_reg   <= nz_next;
        bpos_reg <= bpos_next;
        pos_reg  <= pos_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    assign done = v2_reg;
    assign pos  = pos_reg;

endmodule

// ===== sv/bitmap_with_first_set_tracking.sv =====
// Top level: bitmap of 64-bit words with a cached lowest-set-bit position.
//
// Requests arrive on the s_ stream, one transfer per request; every request
// returns exactly one transfer on the m_ stream. A request is taken only while
// the sequencer is idle, and each one is served by the single memory.
// Set, clear and test bit pass through the read, the registered data (written
// back for set and clear) and the load of the output register; an index out
// of range, set all, clear all, undefined modes and a find with a valid cache go
// straight to the output load. A find with a stale cache scans one word per cycle
// from the lowest up; a word with a set bit goes to the encoder, and an empty
// map ends the scan after the last word.
// A result sits in an output register; when the receiver stalls, the next
// request is still taken and worked on, and waits before its own output load.
// Reset clears the per-word valid bits, so the map reads as all zeros at once;
// set all and clear all reuse the same mechanism.
// The cache reports no set bit after reset.
module bitmap_with_first_set_tracking
    import bwft_pkg::*;
#(
    parameter int WORD_COUNT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // mode [2:0], bit_index [12:3], zero [15:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // bit_value [0], found [1], first_index [11:2], zero [15:12]
);

    localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CW = AW + PosBits;
    localparam int XW = (CW > IndexBits) ? CW : IndexBits;
    localparam int IW = (AW > 4) ? AW : 4;
    localparam int TotalBits = WORD_COUNT * WordBits;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RMW  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_ENC  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [2:0]           mode_reg, mode_next;
    logic [IndexBits-1:0] idx_reg, idx_next;
    logic [AW-1:0]        scan_reg, scan_next;
    logic [CW-1:0]        cached_reg, cached_next;
    logic [1:0]           status_reg, status_next;
    logic                 res_bit_reg, res_bit_next;
    logic                 res_found_reg, res_found_next;
    logic [IndexBits-1:0] res_first_reg, res_first_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [15:0]          m_tdata_reg, m_tdata_next;

    mem_ctl_t             mem_ctl;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    word_t                wr_data;
    word_t                rd_word;
    logic                 enc_start;
    logic                 enc_done;
    logic [PosBits-1:0]   enc_pos;

    logic [2:0]           mode_in;
    logic [IndexBits-1:0] idx_in;
    logic                 in_range_in;
    logic [IW-1:0]        word_in_x;
    logic [IW-1:0]        word_reg_x;
    logic [XW-1:0]        idx_x;
    logic [CW-1:0]        idx_c;
    logic [XW-1:0]        cached_x;
    logic [CW-1:0]        found_pos;
    logic [XW-1:0]        found_x;
    word_t                onehot;

    assign mode_in     = s_tdata[2:0];
    assign idx_in      = s_tdata[12:3];
    assign in_range_in = ({22'd0, idx_in} < 32'(TotalBits));
    assign word_in_x   = IW'(idx_in[9:6]);
    assign word_reg_x  = IW'(idx_reg[9:6]);
    assign idx_x       = XW'(idx_reg);
    assign idx_c       = idx_x[CW-1:0];
    assign cached_x    = XW'(cached_reg);
    assign found_pos   = {scan_reg, enc_pos};
    assign found_x     = XW'(found_pos);
    assign onehot      = word_t'(1) << idx_reg[5:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        idx_next       = idx_reg;
        scan_next      = scan_reg;
        cached_next    = cached_reg;
        status_next    = status_reg;
        res_bit_next   = res_bit_reg;
        res_found_next = res_found_reg;
        res_first_next = res_first_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        mem_ctl        = '0;
        rd_addr        = '0;
        wr_addr        = word_reg_x[AW-1:0];
        wr_data        = rd_word;
        enc_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next      = mode_in;
                    idx_next       = idx_in;
                    res_bit_next   = 1'b0;
                    res_found_next = 1'b0;
                    res_first_next = '0;
                    state_next     = ST_OUT;
                    unique case (mode_in)
                        MODE_SET_BIT, MODE_CLEAR_BIT, MODE_TEST_BIT: begin
                            if (in_range_in) begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = word_in_x[AW-1:0];
                                state_next    = ST_RMW;
                            end
                        end
                        MODE_SET_ALL: begin
                            mem_ctl.bulk_en    = 1'b1;
                            mem_ctl.bulk_value = 1'b1;
                            cached_next        = '0;
                            status_next        = CS_KNOWN;
                        end
                        MODE_CLEAR_ALL: begin
                            mem_ctl.bulk_en    = 1'b1;
                            mem_ctl.bulk_value = 1'b0;
                            cached_next        = '0;
                            status_next        = CS_NONE;
                        end
                        MODE_FIND: begin
                            if (status_reg == CS_UNKNOWN) begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = '0;
                                scan_next     = '0;
                                state_next    = ST_SCAN;
                            end else if (status_reg == CS_KNOWN) begin
                                res_found_next = 1'b1;
                                res_first_next = cached_x[IndexBits-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RMW: begin
                state_next = ST_OUT;
                case (mode_reg)
                    MODE_SET_BIT: begin
                        mem_ctl.wr_en = 1'b1;
                        wr_data       = rd_word | onehot;
                        if (status_reg == CS_NONE ||
                            (status_reg == CS_KNOWN && cached_reg > idx_c)) begin
                            cached_next = idx_c;
                            status_next = CS_KNOWN;
                        end
                    end
                    MODE_CLEAR_BIT: begin
                        mem_ctl.wr_en = 1'b1;
                        wr_data       = rd_word & ~onehot;
                        if (status_reg == CS_KNOWN && cached_reg == idx_c) begin
                            status_next = CS_UNKNOWN;
                        end
                    end
                    default: begin
                        res_bit_next = rd_word[idx_reg[5:0]];
                    end
                endcase
            end
            ST_SCAN: begin
                if (rd_word != '0) begin
                    enc_start  = 1'b1;
                    state_next = ST_ENC;
                end else if (scan_reg == AW'(WORD_COUNT - 1)) begin
                    cached_next = '0;
                    status_next = CS_NONE;
                    state_next  = ST_OUT;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = scan_reg + 1'b1;
                    scan_next     = scan_reg + 1'b1;
                end
            end
            ST_ENC: begin
                if (enc_done) begin
                    cached_next    = found_pos;
                    status_next    = CS_KNOWN;
                    res_found_next = 1'b1;
                    res_first_next = found_x[IndexBits-1:0];
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, res_first_reg, res_found_reg, res_bit_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cached_reg   <= '0;
            status_reg   <= CS_NONE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cached_reg   <= cached_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        idx_reg       <= idx_next;
        scan_reg      <= scan_next;
        res_bit_reg   <= res_bit_next;
        res_found_reg <= res_found_next;
        res_first_reg <= res_first_next;
        m_tdata_reg   <= m_tdata_next;
    end

    bwft_mem #(
        .WORD_COUNT(WORD_COUNT),
        .AW(AW)
    ) u_mem (
        .aclk(aclk),
        .aresetn(aresetn),
        .ctl(mem_ctl),
        .rd_addr(rd_addr),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_word(rd_word)
    );

    bwft_enc u_enc (
        .aclk(aclk),
        .aresetn(aresetn),
        .start(enc_start),
        .word(rd_word),
        .done(enc_done),
        .pos(enc_pos)
    );

`ifndef NO_ASSERTIONS
    a_no_fast_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("Result appeared one cycle after a request transfer.");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT)
        else $error("Result loaded outside the output state.");

    a_scan_needs_stale: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> status_reg == CS_UNKNOWN)
        else $error("Rescan running while the cache is valid.");

    a_set_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg) == ST_RMW && $past(mode_reg) == MODE_SET_BIT
        |-> status_reg != CS_NONE)
        else $error("Cache reports an empty map after a bit was set.");

    a_bit_and_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("Test and find results reported in one transfer.");
`endif

endmodule
